[rtl/meter_bus_frame_receiver_macros.svh]
// Assertion macros for the meter-bus frame receiver.
// Uses i_clk and i_rst_n of the including module; no other dependencies.
`ifndef METER_BUS_FRAME_RECEIVER_MACROS_SVH
`define METER_BUS_FRAME_RECEIVER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define MBFR_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("mbfr check failed");

// Next-cycle implication, checked out of reset.
`define MBFR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("mbfr check failed");

`endif

[rtl/mbfr_pkg.sv]
// Shared constants, codes and types for the meter-bus frame receiver.
// No dependencies.
`timescale 1ns / 1ps

package mbfr_pkg;

    localparam int AddrBytes = 7;
    localparam int AddrWidth = AddrBytes * 8;
    localparam int AddrIdxW  = (AddrBytes > 1) ? $clog2(AddrBytes) : 1;

    localparam logic [7:0] SofByte = 8'h68;
    localparam logic [7:0] EofByte = 8'h16;

    localparam logic [7:0] DevTypeRst = 8'h25;
    localparam logic [7:0] CtrlRst    = 8'h81;
    localparam logic [7:0] MaxLenRst  = 8'h60;

    localparam int CfgIdxW  = 2;
    localparam int CfgDataW = AddrWidth;
    localparam logic [CfgIdxW-1:0] CfgMeterAddr = 2'd0;
    localparam logic [CfgIdxW-1:0] CfgDevType   = 2'd1;
    localparam logic [CfgIdxW-1:0] CfgControl   = 2'd2;
    localparam logic [CfgIdxW-1:0] CfgMaxLen    = 2'd3;

    localparam logic [3:0] StBusy     = 4'd0;
    localparam logic [3:0] StOk       = 4'd1;
    localparam logic [3:0] StStart    = 4'd2;
    localparam logic [3:0] StDevice   = 4'd3;
    localparam logic [3:0] StAddress  = 4'd4;
    localparam logic [3:0] StControl  = 4'd5;
    localparam logic [3:0] StLength   = 4'd6;
    localparam logic [3:0] StChecksum = 4'd7;
    localparam logic [3:0] StEndErr   = 4'd8;

    // One classified byte as it sits in the queue.
    typedef struct packed {
        logic [7:0] data;
        logic       is_sof;
        logic       is_eof;
        logic       dev_ok;
        logic       ctrl_ok;
        logic       len_ok;
        logic       len_zero;
    } t_item;

    // One result beat.
    typedef struct packed {
        logic [3:0]  status;
        logic        payload_valid;
        logic [7:0]  payload_byte;
        logic [7:0]  payload_index;
        logic [15:0] data_identifier;
        logic [7:0]  sequence_number;
        logic [7:0]  data_length;
    } t_result;

endpackage

[rtl/meter_bus_frame_receiver.sv]
// Top level of the meter-bus frame receiver: config registers, front, queue, back.
// Depends on mbfr_pkg, mbfr_front, mbfr_queue, mbfr_back and the macros header.
`timescale 1ns / 1ps
//
// Channel   Direction  Handshake                 Beat contents
// --------  ---------  ------------------------  ------------------------------------
// in        sink       i_in_valid / o_in_ready   i_rx_byte
// out       source     o_out_valid / i_out_ready status, payload and captured fields
// cfg       sink       i_cfg_we (no wait)        i_cfg_index, i_cfg_wdata
//
// Every input beat yields exactly one output beat. A byte accepted into the queue is
// popped from there into the result register, and its beat is then offered on the out
// channel. Sustained rate is one beat per cycle while the output side takes every beat:
// the frame state machine in the back end retires one queued byte per cycle and the
// output register frees as it is taken. A two-entry queue sits between the classifier
// and the state machine, so a stall on the output side backs up into the queue before
// o_in_ready drops.
// Reset (synchronous, active low) clears the queue, the output valid and all frame
// state; config registers return to their documented defaults.

`include "meter_bus_frame_receiver_macros.svh"

module meter_bus_frame_receiver (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [mbfr_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  logic [mbfr_pkg::CfgDataW-1:0] i_cfg_wdata,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [7:0]                    i_rx_byte,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [3:0]                    o_status,
    output logic                          o_payload_valid,
    output logic [7:0]                    o_payload_byte,
    output logic [7:0]                    o_payload_index,
    output logic [15:0]                   o_data_identifier,
    output logic [7:0]                    o_sequence_number,
    output logic [7:0]                    o_data_length
);
    import mbfr_pkg::*;

    // Config registers
    logic [AddrWidth-1:0] r_meter_address;
    logic [7:0]           r_dev_type;
    logic [7:0]           r_control;
    logic [7:0]           r_max_len;

    logic    w_push;
    logic    w_q_ready;
    logic    w_q_valid;
    logic    w_pop;
    t_item   w_front_item;
    t_item   w_q_item;
    t_result w_result;

    // Hold config until written; write only while the frame path is idle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_meter_address <= '0;
            r_dev_type      <= DevTypeRst;
            r_control       <= CtrlRst;
            r_max_len       <= MaxLenRst;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CfgMeterAddr: r_meter_address <= i_cfg_wdata[AddrWidth-1:0];
                CfgDevType:   r_dev_type      <= i_cfg_wdata[7:0];
                CfgControl:   r_control       <= i_cfg_wdata[7:0];
                CfgMaxLen:    r_max_len       <= i_cfg_wdata[7:0];
                default:      r_max_len       <= r_max_len;
            endcase
        end
    end

    // Classify each accepted beat against the fixed and configured bytes.
    mbfr_front u_front (
        .i_in_valid (i_in_valid),
        .i_rx_byte  (i_rx_byte),
        .i_dev_type (r_dev_type),
        .i_control  (r_control),
        .i_max_len  (r_max_len),
        .i_q_ready  (w_q_ready),
        .o_in_ready (o_in_ready),
        .o_push     (w_push),
        .o_item     (w_front_item)
    );

    // Decouple the classifier from the state machine.
    mbfr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .o_ready (w_q_ready),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_item  (w_q_item)
    );

    // Walk the frame and register one result beat per byte.
    mbfr_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_item_valid    (w_q_valid),
        .i_item          (w_q_item),
        .o_pop           (w_pop),
        .i_meter_address (r_meter_address),
        .i_out_ready     (i_out_ready),
        .o_out_valid     (o_out_valid),
        .o_result        (w_result)
    );

    assign o_status          = w_result.status;
    assign o_payload_valid   = w_result.payload_valid;
    assign o_payload_byte    = w_result.payload_byte;
    assign o_payload_index   = w_result.payload_index;
    assign o_data_identifier = w_result.data_identifier;
    assign o_sequence_number = w_result.sequence_number;
    assign o_data_length     = w_result.data_length;

    // A pop must take a queued byte.
    `MBFR_ASSERT_NOW(a_pop_needs_item, w_pop, w_q_valid)
    // A payload beat only appears while the frame is still in progress.
    `MBFR_ASSERT_NOW(a_payload_busy, o_out_valid && o_payload_valid, o_status == StBusy)
    // Captured fields are zero except on a good frame.
    `MBFR_ASSERT_NOW(a_capture_only_ok, o_out_valid && o_status != StOk,
        o_data_length == 8'd0 && o_data_identifier == 16'd0 && o_sequence_number == 8'd0)
    // A popped byte always shows up as an output beat next cycle.
    `MBFR_ASSERT_NEXT(a_pop_gives_beat, w_pop, o_out_valid)

endmodule

[rtl/mbfr_front.sv]
// Front end: classify each incoming byte against the fixed frame bytes and config.
// Depends on mbfr_pkg.
`timescale 1ns / 1ps

module mbfr_front (
    input  logic            i_in_valid,
    input  logic [7:0]      i_rx_byte,
    input  logic [7:0]      i_dev_type,
    input  logic [7:0]      i_control,
    input  logic [7:0]      i_max_len,
    input  logic            i_q_ready,
    output logic            o_in_ready,
    output logic            o_push,
    output mbfr_pkg::t_item o_item
);
    import mbfr_pkg::*;

    assign o_in_ready = i_q_ready;
    assign o_push     = i_in_valid & i_q_ready;

    always_comb begin
        o_item.data     = i_rx_byte;
        o_item.is_sof   = (i_rx_byte == SofByte);
        o_item.is_eof   = (i_rx_byte == EofByte);
        o_item.dev_ok   = (i_rx_byte == i_dev_type);
        o_item.ctrl_ok  = (i_rx_byte == i_control);
        o_item.len_ok   = (i_rx_byte <= i_max_len);
        o_item.len_zero = (i_rx_byte == 8'd0);
    end

endmodule

[rtl/mbfr_queue.sv]
// Two-entry queue of classified bytes between front and back.
// Depends on mbfr_pkg.
`timescale 1ns / 1ps

module mbfr_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  mbfr_pkg::t_item i_item,
    output logic            o_ready,
    input  logic            i_pop,
    output logic            o_valid,
    output mbfr_pkg::t_item o_item
);
    import mbfr_pkg::*;

    t_item      r_slot [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_item  = r_slot[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

[rtl/mbfr_back.sv]
// Back end: frame state machine, checksum, capture and registered result beat.
// Depends on mbfr_pkg.
`timescale 1ns / 1ps

module mbfr_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_item_valid,
    input  mbfr_pkg::t_item                i_item,
    output logic                           o_pop,
    input  logic [mbfr_pkg::AddrWidth-1:0] i_meter_address,
    input  logic                           i_out_ready,
    output logic                           o_out_valid,
    output mbfr_pkg::t_result              o_result
);
    import mbfr_pkg::*;

    localparam logic [2:0] PhStart = 3'd0;
    localparam logic [2:0] PhDev   = 3'd1;
    localparam logic [2:0] PhAddr  = 3'd2;
    localparam logic [2:0] PhCtrl  = 3'd3;
    localparam logic [2:0] PhLen   = 3'd4;
    localparam logic [2:0] PhData  = 3'd5;
    localparam logic [2:0] PhCheck = 3'd6;
    localparam logic [2:0] PhEnd   = 3'd7;

    logic [2:0]  r_phase, n_phase;
    logic [7:0]  r_sum, n_sum;
    logic [7:0]  r_count, n_count;
    logic [7:0]  r_len, n_len;
    logic [15:0] r_ident, n_ident;
    logic [7:0]  r_seq, n_seq;
    logic        r_out_valid;
    t_result     r_result;
    t_result     w_res;

    logic [AddrIdxW-1:0] w_k;
    logic [7:0]          w_want;
    logic [7:0]          w_sum_add;
    logic [7:0]          w_count_inc;

    assign o_pop       = i_item_valid & (~r_out_valid | i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;

    assign w_k         = AddrIdxW'(r_count - 8'd1);
    assign w_want      = i_meter_address[8*w_k +: 8];
    assign w_sum_add   = r_sum + i_item.data;
    assign w_count_inc = r_count + 8'd1;

    always_comb begin
        n_phase = r_phase;
        n_sum   = r_sum;
        n_count = r_count;
        n_len   = r_len;
        n_ident = r_ident;
        n_seq   = r_seq;
        w_res   = '0;
        w_res.status = StBusy;
        if (o_pop) begin
            case (r_phase)
                PhStart: begin
                    if (!i_item.is_sof) begin
                        w_res.status = StStart;
                    end else begin
                        n_sum   = i_item.data;
                        n_ident = 16'd0;
                        n_seq   = 8'd0;
                        n_phase = PhDev;
                    end
                end
                PhDev: begin
                    if (!i_item.dev_ok) begin
                        w_res.status = StDevice;
                        n_phase      = PhStart;
                    end else begin
                        n_sum   = w_sum_add;
                        n_count = 8'(AddrBytes);
                        n_phase = PhAddr;
                    end
                end
                PhAddr: begin
                    if (r_count == 8'd0 || i_item.data != w_want) begin
                        w_res.status = StAddress;
                        n_phase      = PhStart;
                    end else begin
                        n_sum   = w_sum_add;
                        n_count = r_count - 8'd1;
                        if (r_count == 8'd1) begin
                            n_phase = PhCtrl;
                        end
                    end
                end
                PhCtrl: begin
                    if (!i_item.ctrl_ok) begin
                        w_res.status = StControl;
                        n_phase      = PhStart;
                    end else begin
                        n_sum   = w_sum_add;
                        n_phase = PhLen;
                    end
                end
                PhLen: begin
                    if (!i_item.len_ok) begin
                        w_res.status = StLength;
                        n_phase      = PhStart;
                    end else begin
                        n_sum   = w_sum_add;
                        n_len   = i_item.data;
                        n_count = 8'd0;
                        n_phase = i_item.len_zero ? PhCheck : PhData;
                    end
                end
                PhData: begin
                    n_sum = w_sum_add;
                    case (r_count)
                        8'd0:    n_ident[7:0]  = i_item.data;
                        8'd1:    n_ident[15:8] = i_item.data;
                        8'd2:    n_seq         = i_item.data;
                        default: begin
                            w_res.payload_valid = 1'b1;
                            w_res.payload_byte  = i_item.data;
                            w_res.payload_index = r_count - 8'd3;
                        end
                    endcase
                    n_count = w_count_inc;
                    if (w_count_inc == r_len) begin
                        n_phase = PhCheck;
                    end
                end
                PhCheck: begin
                    if (i_item.data != r_sum) begin
                        w_res.status = StChecksum;
                        n_phase      = PhStart;
                    end else begin
                        n_phase = PhEnd;
                    end
                end
                default: begin
                    n_phase = PhStart;
                    if (!i_item.is_eof) begin
                        w_res.status = StEndErr;
                    end else begin
                        w_res.status          = StOk;
                        w_res.data_identifier = r_ident;
                        w_res.sequence_number = r_seq;
                        w_res.data_length     = r_len;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PhStart;
            r_sum       <= 8'd0;
            r_count     <= 8'd0;
            r_len       <= 8'd0;
            r_ident     <= 16'd0;
            r_seq       <= 8'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_sum   <= n_sum;
            r_count <= n_count;
            r_len   <= n_len;
            r_ident <= n_ident;
            r_seq   <= n_seq;
            if (o_pop) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_result <= w_res;
        end
    end

endmodule

[dv/meter_bus_frame_receiver_tb.sv]
// Self-checking testbench for the meter-bus frame receiver: framed byte streams with
// random content and faults are decoded by a local frame model and compared beat by beat.
// Depends on mbfr_pkg and meter_bus_frame_receiver.
`timescale 1ns / 1ps

module meter_bus_frame_receiver_tb;
    import mbfr_pkg::*;

    localparam int IdleLimit = 1000;

    // Frame decoder phases, kept by the local model.
    typedef enum logic [2:0] {
        HUNT, DEVICE, ADDRESS, CONTROL, LENGTH, DATA, CHECK, TRAILER
    } rx_phase_e;

    // Kinds of frame that the stimulus builds.
    typedef enum int {
        FR_GOOD, FR_BAD_DEV, FR_BAD_ADDR, FR_BAD_CTRL, FR_BAD_LEN,
        FR_BAD_SUM, FR_BAD_END, FR_CUT
    } frame_kind_e;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_we = 1'b0;
    logic [CfgIdxW-1:0]  i_cfg_index = '0;
    logic [CfgDataW-1:0] i_cfg_wdata = '0;
    logic                i_in_valid = 1'b0;
    logic                o_in_ready;
    logic [7:0]          i_rx_byte = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    logic [3:0]          o_status;
    logic                o_payload_valid;
    logic [7:0]          o_payload_byte;
    logic [7:0]          o_payload_index;
    logic [15:0]         o_data_identifier;
    logic [7:0]          o_sequence_number;
    logic [7:0]          o_data_length;

    meter_bus_frame_receiver DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_rx_byte         (i_rx_byte),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_status          (o_status),
        .o_payload_valid   (o_payload_valid),
        .o_payload_byte    (o_payload_byte),
        .o_payload_index   (o_payload_index),
        .o_data_identifier (o_data_identifier),
        .o_sequence_number (o_sequence_number),
        .o_data_length     (o_data_length)
    );

    // Local copy of the registers, tracking every write.
    logic [AddrWidth-1:0] cfg_addr = '0;
    logic [7:0]           cfg_dev = DevTypeRst;
    logic [7:0]           cfg_ctrl = CtrlRst;
    logic [7:0]           cfg_max = MaxLenRst;

    // Local copy of the frame state, at its reset values.
    rx_phase_e   rx_phase = HUNT;
    logic [7:0]  frame_sum = '0;
    logic [7:0]  rx_count = '0;
    logic [7:0]  len_held = '0;
    logic [15:0] id_held = '0;
    logic [7:0]  seq_held = '0;

    logic [7:0] rx_backlog[$];      // bytes waiting to be sent
    t_result    decoded_results[$]; // results still owed by the block

    int unsigned in_beats = 0;
    int unsigned out_beats = 0;
    int unsigned in_seen = 0;
    int unsigned out_seen = 0;
    int          send_gap = 0;
    int          take_stall = 0;
    bit          send_burst = 1'b0;
    bit          take_burst = 1'b0;
    int          idle_cycles = 0;
    int          mismatches = 0;

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Decode one received byte exactly as the frame parser should, and return the beat
    // that it has to produce.
    function automatic t_result decode_byte(input logic [7:0] b);
        t_result r;
        int      k;
        r = '0;
        r.status = StBusy;
        case (rx_phase)
            HUNT: begin
                // Anything but a start byte is line noise.
                if (b != SofByte) begin
                    r.status = StStart;
                end else begin
                    frame_sum = b;
                    id_held = '0;
                    seq_held = '0;
                    rx_phase = DEVICE;
                end
            end
            DEVICE: begin
                if (b != cfg_dev) begin
                    r.status = StDevice;
                    rx_phase = HUNT;
                end else begin
                    frame_sum += b;
                    rx_count = 8'(AddrBytes);
                    rx_phase = ADDRESS;
                end
            end
            ADDRESS: begin
                // The top address byte arrives first.
                k = (int'(rx_count) - 1) & 7;
                if (rx_count == 0 || b != cfg_addr[8*k +: 8]) begin
                    r.status = StAddress;
                    rx_phase = HUNT;
                end else begin
                    frame_sum += b;
                    rx_count--;
                    if (rx_count == 0) rx_phase = CONTROL;
                end
            end
            CONTROL: begin
                if (b != cfg_ctrl) begin
                    r.status = StControl;
                    rx_phase = HUNT;
                end else begin
                    frame_sum += b;
                    rx_phase = LENGTH;
                end
            end
            LENGTH: begin
                if (b > cfg_max) begin
                    r.status = StLength;
                    rx_phase = HUNT;
                end else begin
                    frame_sum += b;
                    len_held = b;
                    rx_count = '0;
                    // An empty data field skips straight to the checksum.
                    rx_phase = (b == 0) ? CHECK : DATA;
                end
            end
            DATA: begin
                frame_sum += b;
                case (rx_count)
                    8'd0: id_held[7:0] = b;
                    8'd1: id_held[15:8] = b;
                    8'd2: seq_held = b;
                    default: begin
                        r.payload_valid = 1'b1;
                        r.payload_byte = b;
                        r.payload_index = rx_count - 8'd3;
                    end
                endcase
                rx_count++;
                if (rx_count == len_held) rx_phase = CHECK;
            end
            CHECK: begin
                if (b != frame_sum) begin
                    r.status = StChecksum;
                    rx_phase = HUNT;
                end else begin
                    rx_phase = TRAILER;
                end
            end
            default: begin
                rx_phase = HUNT;
                if (b != EofByte) begin
                    r.status = StEndErr;
                end else begin
                    r.status = StOk;
                    r.data_identifier = id_held;
                    r.sequence_number = seq_held;
                    r.data_length = len_held;
                end
            end
        endcase
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    function automatic int draw_wait(input bit burst);
        return burst ? 0 : $urandom_range(0, 5);
    endfunction

    function automatic logic [7:0] flip_mask();
        return 8'($urandom_range(1, 255));
    endfunction

    // Build one frame from the current register values, spoil it as asked, and queue it.
    task automatic push_frame(input frame_kind_e kind, input int len);
        logic [7:0] fr[$];
        logic [7:0] cs;
        int         keep;
        fr = {};
        fr.push_back(SofByte);
        fr.push_back(cfg_dev);
        for (int i = AddrBytes - 1; i >= 0; i--) fr.push_back(cfg_addr[8*i +: 8]);
        fr.push_back(cfg_ctrl);
        fr.push_back(8'(len));
        // An oversized length ends the frame; leave the body off.
        if (kind != FR_BAD_LEN) begin
            for (int i = 0; i < len; i++) fr.push_back(8'($urandom));
            cs = '0;
            foreach (fr[i]) cs += fr[i];
            fr.push_back(cs);
            fr.push_back(EofByte);
        end
        case (kind)
            FR_BAD_DEV:  fr[1] ^= flip_mask();
            FR_BAD_ADDR: fr[$urandom_range(2, 1 + AddrBytes)] ^= flip_mask();
            FR_BAD_CTRL: fr[AddrBytes + 2] ^= flip_mask();
            FR_BAD_SUM:  fr[fr.size() - 2] ^= flip_mask();
            FR_BAD_END:  fr[fr.size() - 1] ^= flip_mask();
            FR_CUT: begin
                // Drop the tail; the next frame lands in the middle of this one.
                keep = $urandom_range(1, fr.size() - 1);
                while (fr.size() > keep) void'(fr.pop_back());
            end
            default: ;
        endcase
        foreach (fr[i]) rx_backlog.push_back(fr[i]);
    endtask

    // Queue a mix of well-formed frames, spoiled frames and noise.
    task automatic fill_phase(input int target);
        int          added;
        int          pick;
        int          len;
        frame_kind_e kind;
        added = rx_backlog.size();
        while (rx_backlog.size() - added < target) begin
            if ($urandom_range(0, 7) == 0) begin
                repeat ($urandom_range(1, 4)) rx_backlog.push_back(8'($urandom));
            end
            pick = $urandom_range(0, 99);
            if      (pick < 55) kind = FR_GOOD;
            else if (pick < 61) kind = FR_BAD_DEV;
            else if (pick < 68) kind = FR_BAD_ADDR;
            else if (pick < 73) kind = FR_BAD_CTRL;
            else if (pick < 79) kind = FR_BAD_LEN;
            else if (pick < 86) kind = FR_BAD_SUM;
            else if (pick < 92) kind = FR_BAD_END;
            else                kind = FR_CUT;
            if (kind == FR_BAD_LEN && cfg_max == 8'hFF) kind = FR_BAD_SUM;
            // Keep most frames short; now and then draw from the full allowed length range.
            if (kind == FR_BAD_LEN)
                len = $urandom_range(int'(cfg_max) + 1, 255);
            else if ($urandom_range(0, 19) == 0)
                len = $urandom_range(0, cfg_max);
            else
                len = $urandom_range(0, (cfg_max < 12) ? cfg_max : 12);
            push_frame(kind, len);
        end
    endtask

    // Hold until every byte is sent and every result has come back.
    task automatic drain();
        while (rx_backlog.size() != 0 || i_in_valid || decoded_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Write all four registers on back-to-back cycles; call only while the block is idle.
    task automatic set_config(input logic [AddrWidth-1:0] addr, input logic [7:0] dev,
                              input logic [7:0] ctrl, input logic [7:0] max_len);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= CfgMeterAddr;
        i_cfg_wdata <= CfgDataW'(addr);
        cfg_addr = addr;
        @(negedge i_clk);
        i_cfg_index <= CfgDevType;
        i_cfg_wdata <= CfgDataW'(dev);
        cfg_dev = dev;
        @(negedge i_clk);
        i_cfg_index <= CfgControl;
        i_cfg_wdata <= CfgDataW'(ctrl);
        cfg_ctrl = ctrl;
        @(negedge i_clk);
        i_cfg_index <= CfgMaxLen;
        i_cfg_wdata <= CfgDataW'(max_len);
        cfg_max = max_len;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Input driver: hold a beat until it is taken, then wait a random gap before the next.
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || in_beats != in_seen)) begin
            if (in_beats != in_seen) begin
                in_seen = in_beats;
                if ($urandom_range(0, 49) == 0) send_burst = !send_burst;
                send_gap = draw_wait(send_burst);
            end
            if (send_gap > 0) begin
                send_gap--;
                i_in_valid <= 1'b0;
            end else if (rx_backlog.size() > 0) begin
                i_in_valid <= 1'b1;
                i_rx_byte <= rx_backlog.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Output side: after each beat taken, hold ready low for a randomly drawn stall, none in burst mode.
    always @(negedge i_clk) begin
        if (out_beats != out_seen) begin
            out_seen = out_beats;
            if ($urandom_range(0, 49) == 0) take_burst = !take_burst;
            take_stall = draw_wait(take_burst);
        end
        if (take_stall > 0) begin
            take_stall--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Monitor: decode every accepted byte, check every taken result, watch for a hang.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                decoded_results.push_back(decode_byte(i_rx_byte));
                in_beats++;
            end
            if (o_out_valid && i_out_ready) begin
                out_beats++;
                if (decoded_results.size() == 0) begin
                    $error("result beat with no byte pending, status %0d", o_status);
                    mismatches++;
                end else begin
                    want = decoded_results.pop_front();
                    check_field("status", want.status, o_status);
                    check_field("payload_valid", want.payload_valid, o_payload_valid);
                    check_field("payload_byte", want.payload_byte, o_payload_byte);
                    check_field("payload_index", want.payload_index, o_payload_index);
                    check_field("data_identifier", want.data_identifier, o_data_identifier);
                    check_field("sequence_number", want.sequence_number, o_sequence_number);
                    check_field("data_length", want.data_length, o_data_length);
                end
            end
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || i_cfg_we)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IdleLimit) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial begin
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: noise, an empty frame at the reset settings, then a length one past
        // the limit.
        rx_backlog.push_back(8'hFF);
        push_frame(FR_GOOD, 0);
        push_frame(FR_BAD_LEN, int'(cfg_max) + 1);
        drain();

        // Random phases; the first runs at reset values, then extremes, then random.
        for (int p = 0; p < 8; p++) begin
            if (p == 1)
                set_config('1, 8'h00, 8'hFF, 8'h00);
            else if (p == 2)
                set_config('0, 8'hFF, 8'h00, 8'hFF);
            else if (p > 2)
                set_config(AddrWidth'({$urandom, $urandom}), 8'($urandom), 8'($urandom),
                           ($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 3))
                                                       : 8'($urandom_range(4, 255)));
            fill_phase(250);
            drain();
        end

        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && decoded_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl
rtl/mbfr_pkg.sv
rtl/mbfr_front.sv
rtl/mbfr_queue.sv
rtl/mbfr_back.sv
rtl/meter_bus_frame_receiver.sv
dv/meter_bus_frame_receiver_tb.sv
